// ----- sv/tssm_pkg.sv -----
// Shared types and constants for the two-stacks shared-memory block.
package tssm_pkg;

	// Default sizing of the shared entry memory
	localparam int DEPTH_DEF       = 256;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int CAP_W      = 9;
	localparam int OPC_W      = 3;
	localparam int DATA_W     = 32;
	localparam int STAT_W     = 2;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 56;

	// Capacity register after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	// Operation codes
	typedef enum logic [OPC_W-1:0] {
		OP_PUSH1 = 3'd0,
		OP_PUSH2 = 3'd1,
		OP_POP1  = 3'd2,
		OP_POP2  = 3'd3,
		OP_PEEK1 = 3'd4,
		OP_PEEK2 = 3'd5
	} opcode_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Per-item result information that travels alongside the memory read
	typedef struct packed {
		logic             rd;
		status_t          status;
		logic [CAP_W-1:0] size_one;
		logic [CAP_W-1:0] size_two;
	} meta_t;

endpackage

// ----- sv/tssm_mem.sv -----
// Single-port entry memory with a registered read.
module tssm_mem #(
	parameter int DEPTH       = tssm_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = tssm_pkg::VALUE_WIDTH_DEF,
	parameter int AW          = $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic                   re,
	input  logic [AW-1:0]          addr,
	input  logic [VALUE_WIDTH-1:0] wdata,
	output logic [VALUE_WIDTH-1:0] rdata
);

	logic [VALUE_WIDTH-1:0] mem_q [DEPTH];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	// Read the addressed entry into the output register
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- sv/tssm_ctrl.sv -----
// Stack pointers, capacity register and operation decode for the shared memory.
module tssm_ctrl #(
	parameter int DEPTH       = tssm_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = tssm_pkg::VALUE_WIDTH_DEF,
	parameter int AW          = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [tssm_pkg::OPC_W-1:0]        opcode,
	input  logic signed [tssm_pkg::DATA_W-1:0] push_value,
	input  logic                              cfg_we,
	input  logic [tssm_pkg::CAP_W-1:0]        cfg_wdata,
	output logic                              mem_we,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_addr,
	output logic [VALUE_WIDTH-1:0]            mem_wdata,
	output tssm_pkg::meta_t                   meta
);

	localparam int CAP_W   = tssm_pkg::CAP_W;
	localparam int CAP_LIM = (DEPTH > 511) ? 511 : DEPTH;

	logic [CAP_W-1:0]       cap_q, one_q, two_q;
	logic [CAP_W-1:0]       cap_eff, nxt_one, nxt_two, addr9;
	logic [CAP_W:0]         used;
	logic                   full, we_c, re_c;
	tssm_pkg::status_t      status_c;
	tssm_pkg::opcode_t      op;
	logic [AW+CAP_W-1:0]    addr_wide;
	logic [VALUE_WIDTH+tssm_pkg::DATA_W-1:0] wd_wide;

	// Clamp the configured capacity to the memory depth
	assign cap_eff = (cap_q > CAP_W'(CAP_LIM)) ? CAP_W'(CAP_LIM) : cap_q;
	assign used    = {1'b0, one_q} + {1'b0, two_q};
	assign full    = used >= {1'b0, cap_eff};
	assign op      = tssm_pkg::opcode_t'(opcode);

	// Decode the operation: at most one memory access and, for pushes and pops, a pointer update
	always_comb begin
		nxt_one  = one_q;
		nxt_two  = two_q;
		we_c     = 1'b0;
		re_c     = 1'b0;
		addr9    = '0;
		status_c = tssm_pkg::ST_OK;
		unique case (op) inside
			tssm_pkg::OP_PUSH1: begin
				if (full) begin
					status_c = tssm_pkg::ST_OVERFLOW;
				end else begin
					we_c    = 1'b1;
					addr9   = one_q;
					nxt_one = one_q + 1'b1;
				end
			end
			tssm_pkg::OP_PUSH2: begin
				if (full) begin
					status_c = tssm_pkg::ST_OVERFLOW;
				end else begin
					we_c    = 1'b1;
					addr9   = cap_eff - two_q - 1'b1;
					nxt_two = two_q + 1'b1;
				end
			end
			tssm_pkg::OP_POP1, tssm_pkg::OP_PEEK1: begin
				if (one_q == '0) begin
					status_c = tssm_pkg::ST_UNDERFLOW;
				end else begin
					re_c  = 1'b1;
					addr9 = one_q - 1'b1;
					if (op == tssm_pkg::OP_POP1) begin
						nxt_one = one_q - 1'b1;
					end
				end
			end
			tssm_pkg::OP_POP2, tssm_pkg::OP_PEEK2: begin
				if (two_q == '0) begin
					status_c = tssm_pkg::ST_UNDERFLOW;
				end else begin
					re_c  = 1'b1;
					addr9 = cap_eff - two_q;
					if (op == tssm_pkg::OP_POP2) begin
						nxt_two = two_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Fit address and data to the memory widths
	assign addr_wide = {{AW{1'b0}}, addr9};
	assign wd_wide   = {{VALUE_WIDTH{1'b0}}, push_value};
	assign mem_addr  = addr_wide[AW-1:0];
	assign mem_wdata = wd_wide[VALUE_WIDTH-1:0];
	assign mem_we    = accept & we_c;
	assign mem_re    = accept & re_c;

	assign meta.rd       = re_c;
	assign meta.status   = status_c;
	assign meta.size_one = nxt_one;
	assign meta.size_two = nxt_two;

	// Hold capacity and stack sizes; a capacity write empties both stacks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= tssm_pkg::CAP_RESET;
			one_q <= '0;
			two_q <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
			one_q <= '0;
			two_q <= '0;
		end else if (accept) begin
			one_q <= nxt_one;
			two_q <= nxt_two;
		end
	end

	// The two stacks never hold more than the clamped capacity
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		used <= {1'b0, cap_eff})
		else $error("stacks overlap in shared memory");

	// An overflowing push leaves both stacks unchanged
	a_overflow_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_we && status_c == tssm_pkg::ST_OVERFLOW
		|=> $stable(one_q) && $stable(two_q))
		else $error("overflowing push changed a stack size");

	// Memory is never written and read by the same item
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("write and read issued together");

endmodule

// ----- sv/two_stacks_shared_memory_top.sv -----
// Top level of the two-stacks shared-memory block: stream ports and result stages.
//
// Two LIFO stacks share one memory: stack one grows up from entry 0, stack two
// grows down from the configured capacity minus one (clamped to DEPTH). Each
// input transfer carries one push, pop or peek and gives exactly one result
// transfer with the value read, a status and both stack sizes. An item is
// taken every cycle while results are drained; its result passes through the
// read stage (the memory read and result information load at the accepting
// edge) and then the output register, which offers it on m_tdata. The single
// memory port, one access per item, sets that rate.
// Writing the capacity register empties both stacks; write it only while no
// item is in flight.
module two_stacks_shared_memory_top #(
	parameter int DEPTH       = tssm_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = tssm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: opcode [2:0], push_value [34:3], zero [39:35]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tssm_pkg::S_TDATA_W-1:0]      s_tdata,
	// m_tdata: read_value [31:0], status [33:32], size_one [42:34],
	// size_two [51:43], zero [55:52]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tssm_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [tssm_pkg::CAP_W-1:0]          cfg_wdata
);

	localparam int AW     = $clog2(DEPTH);
	localparam int DATA_W = tssm_pkg::DATA_W;

	logic                   accept, adv_s1;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_addr;
	logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
	tssm_pkg::meta_t        meta, meta_s1, meta_q;
	logic                   valid_s1, out_valid_q;
	logic [DATA_W-1:0]      read_value_q, read_value;
	logic [VALUE_WIDTH+DATA_W-1:0] rd_wide;

	// Take a transfer when the read stage is empty or moving on
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	tssm_ctrl #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (s_tdata[2:0]),
		.push_value (s_tdata[34:3]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.meta       (meta)
	);

	tssm_mem #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Read stage: result information waits beside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// Select the read data, zero when nothing was read
	assign rd_wide    = {{DATA_W{1'b0}}, mem_rdata};
	assign read_value = meta_s1.rd ? rd_wide[DATA_W-1:0] : '0;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			meta_q       <= meta_s1;
			read_value_q <= read_value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, meta_q.size_two, meta_q.size_one, meta_q.status, read_value_q};

	// An underflow result always carries a zero value
	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && meta_q.status == tssm_pkg::ST_UNDERFLOW |-> read_value_q == '0)
		else $error("underflow result with non-zero value");

	// A stalled read stage keeps its item
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("read stage dropped an item");

endmodule
